### hw/rtl/bthin_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the binary thinning block.
package bthin_pkg;

  // Item command codes.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // Eight neighbors in ring order, bit i is ring position i.
  typedef logic [7:0] ring_t;

  // Outcome of the neighborhood tests for one pixel.
  typedef struct packed {
    logic cnt_ok;
    logic trans_ok;
    logic side_ok;
  } eval_t;

endpackage

### hw/rtl/bthin_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bthin_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bthin_eval.sv
`timescale 1ns / 1ps
// Neighborhood tests of one thinning step: count, transitions and side rule.
module bthin_eval
  import bthin_pkg::*;
(
  input  ring_t ring,
  input  logic  phase,
  output eval_t res
);

  logic [3:0] cnt;
  logic [3:0] trans;

  // Count set neighbors and 0-to-1 steps going round the ring.
  always_comb begin
    cnt   = '0;
    trans = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(ring[i]);
      if (!ring[i] && ring[(i + 1) % 8]) begin
        trans = trans + 4'd1;
      end
    end
  end

  // Phase 1 looks at the west and north sides, phase 0 at south and east.
  always_comb begin
    res.cnt_ok   = (cnt >= 4'd2) && (cnt <= 4'd6);
    res.trans_ok = (trans == 4'd1);
    if (phase) begin
      res.side_ok = !ring[1] || !ring[7] || (!ring[3] && !ring[5]);
    end else begin
      res.side_ok = !ring[3] || !ring[5] || (!ring[1] && !ring[7]);
    end
  end

endmodule

### hw/rtl/binary_thinning_two_subpass.sv
`timescale 1ns / 1ps
// Top level of the binary thinning block: image store, sequencer and I/O.
//
// The block holds a binary image and thins it in place with alternating
// sub-passes. Items arrive on the in_ channel (valid/stall): a load writes
// one pixel, a read returns one pixel, a run thins the area in use. Every
// item gives exactly one result on the out_ channel, carrying the read
// pixel (0 for other commands) and the sub-pass count of the last run.
// Load and read items present their result through the response state after
// acceptance; the next item is accepted only once that result is taken. A run
// clears the border, then per sub-pass reads the nine neighborhood pixels of
// each interior pixel through the single image read port and removes the
// marked ones, until a sub-pass removes nothing, then clears the border again.
// While the receiver stalls, the result holds and no new item is accepted.
// Reset clears the control state, sets the size registers to 256, the sub-pass
// count to zero; image contents are unknown until written. The cfg_ port is
// always ready; the user must write it only while idle, unchecked by the block.
module binary_thinning_two_subpass
  import bthin_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_pixel_col,
  input  logic [7:0]  in_pixel_row,
  input  logic        in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pixel_out,
  output logic [15:0] out_subpass_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CPW   = $clog2(MAX_WIDTH);
  localparam int RPW   = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_B1, S_SUB, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_DEC,
    S_APP_RD, S_APP_WR, S_B2
  } state_t;

  state_t         state_r;
  logic [8:0]     cfg_w_r, cfg_h_r;
  logic [WW-1:0]  w_r, w_clamp;
  logic [HW-1:0]  h_r, h_clamp;
  logic [CPW-1:0] c_r, c_nxt, c_hi;
  logic [RPW-1:0] r_r, r_nxt, r_hi;
  logic [AW-1:0]  base_r, base_nxt, cur_addr, item_addr;
  logic [3:0]     k_r, cap_k_r;
  logic           cap_v_r;
  logic [8:0]     nb_r;
  logic           phase_r, removed_r;
  logic [15:0]    cnt_r;
  logic [1:0]     cmd_r;
  logic           inside_r, item_inside;
  logic           out_valid_r, out_pix_r;
  logic [15:0]    out_cnt_r;
  logic           in_acc, interior, row_end, last_pos, on_border, rm;
  logic           px_we, px_wdata, px_rdata, mk_we, mk_rdata;
  logic [AW-1:0]  px_waddr, px_raddr;
  eval_t          ev;

  // Ring offsets: slot 0 is the center, slots 1..8 are ring positions 0..7.
  function automatic logic [AW-1:0] nb_off(input logic [3:0] k);
    unique case (k)
      4'd1:    nb_off = ~MW_A;
      4'd2:    nb_off = {AW{1'b1}};
      4'd3:    nb_off = MW_A - AW'(1);
      4'd4:    nb_off = MW_A;
      4'd5:    nb_off = MW_A + AW'(1);
      4'd6:    nb_off = AW'(1);
      4'd7:    nb_off = ~MW_A + AW'(2);
      4'd8:    nb_off = ~MW_A + AW'(1);
      default: nb_off = '0;
    endcase
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = !((state_r == S_IDLE) && !out_valid_r);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_pixel_out     = out_pix_r;
  assign out_subpass_count = out_cnt_r;

  // Size registers clamped to the legal range at the start of a run.
  always_comb begin
    if (cfg_w_r < 9'd3) begin
      w_clamp = WW'(3);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_w_r);
    end
    if (cfg_h_r < 9'd3) begin
      h_clamp = HW'(3);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(cfg_h_r);
    end
  end

  // Item address and storage bounds check.
  assign item_inside = (32'(in_pixel_col) < MAX_WIDTH) && (32'(in_pixel_row) < MAX_HEIGHT);
  assign item_addr   = AW'(AW'(in_pixel_row) * MW_A) + AW'(in_pixel_col);

  // Raster position stepping: interior sweeps skip the border ring.
  assign interior  = (state_r == S_SCAN_RD) || (state_r == S_SCAN_WAIT) ||
                     (state_r == S_SCAN_DEC) || (state_r == S_APP_RD) ||
                     (state_r == S_APP_WR);
  assign c_hi      = interior ? CPW'(w_r - WW'(2)) : CPW'(w_r - WW'(1));
  assign r_hi      = interior ? RPW'(h_r - HW'(2)) : RPW'(h_r - HW'(1));
  assign row_end   = (c_r == c_hi);
  assign last_pos  = row_end && (r_r == r_hi);
  assign cur_addr  = base_r + AW'(c_r);
  assign on_border = (c_r == '0) || (c_r == CPW'(w_r - WW'(1))) ||
                     (r_r == '0) || (r_r == RPW'(h_r - HW'(1)));

  always_comb begin
    if (row_end) begin
      c_nxt    = CPW'(interior);
      r_nxt    = r_r + RPW'(1);
      base_nxt = base_r + MW_A;
    end else begin
      c_nxt    = c_r + CPW'(1);
      r_nxt    = r_r;
      base_nxt = base_r;
    end
  end

  // Shared neighborhood test unit.
  bthin_eval u_eval (
    .ring  (nb_r[8:1]),
    .phase (phase_r),
    .res   (ev)
  );

  assign rm = nb_r[0] && ev.cnt_ok && ev.trans_ok && ev.side_ok;

  // Image store port control.
  always_comb begin
    px_we    = 1'b0;
    px_waddr = cur_addr;
    px_wdata = 1'b0;
    px_raddr = cur_addr + nb_off(k_r);
    unique case (state_r)
      S_IDLE: begin
        px_we    = in_acc && (in_cmd == CMD_LOAD) && item_inside;
        px_waddr = item_addr;
        px_wdata = in_pixel_in;
        px_raddr = item_addr;
      end
      S_B1, S_B2: px_we = on_border;
      S_APP_WR:   px_we = mk_rdata;
      default:    px_we = 1'b0;
    endcase
  end

  assign mk_we = (state_r == S_SCAN_DEC);

  bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pixels (
    .clk   (clk),
    .we    (px_we),
    .waddr (px_waddr),
    .wdata (px_wdata),
    .raddr (px_raddr),
    .rdata (px_rdata)
  );

  bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
    .clk   (clk),
    .we    (mk_we),
    .waddr (cur_addr),
    .wdata (rm),
    .raddr (cur_addr),
    .rdata (mk_rdata)
  );

  // Neighborhood capture: read data arrives in the cycle after each address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_v_r <= 1'b0;
    end else begin
      cap_v_r <= (state_r == S_SCAN_RD);
    end
    cap_k_r <= k_r;
    if (cap_v_r) begin
      nb_r[cap_k_r] <= px_rdata;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 9'd256;
      cfg_h_r <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) begin
        cfg_w_r <= cfg_data;
      end else if (cfg_index == CFG_HEIGHT) begin
        cfg_h_r <= cfg_data;
      end
    end
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      removed_r   <= 1'b0;
      k_r         <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r    <= in_cmd;
            inside_r <= item_inside;
            if (in_cmd == CMD_RUN) begin
              w_r     <= w_clamp;
              h_r     <= h_clamp;
              c_r     <= '0;
              r_r     <= '0;
              base_r  <= '0;
              cnt_r   <= '0;
              phase_r <= 1'b0;
              state_r <= S_B1;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_B1: begin
          if (last_pos) begin
            state_r <= S_SUB;
          end else begin
            c_r    <= c_nxt;
            r_r    <= r_nxt;
            base_r <= base_nxt;
          end
        end
        S_SUB: begin
          phase_r   <= ~phase_r;
          if (cnt_r != 16'hFFFF) begin
            cnt_r <= cnt_r + 16'd1;
          end
          removed_r <= 1'b0;
          c_r       <= CPW'(1);
          r_r       <= RPW'(1);
          base_r    <= MW_A;
          k_r       <= '0;
          state_r   <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (k_r == 4'd8) begin
            state_r <= S_SCAN_WAIT;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_SCAN_WAIT: state_r <= S_SCAN_DEC;
        S_SCAN_DEC: begin
          removed_r <= removed_r || rm;
          k_r       <= '0;
          if (last_pos) begin
            c_r     <= CPW'(1);
            r_r     <= RPW'(1);
            base_r  <= MW_A;
            state_r <= S_APP_RD;
          end else begin
            c_r     <= c_nxt;
            r_r     <= r_nxt;
            base_r  <= base_nxt;
            state_r <= S_SCAN_RD;
          end
        end
        S_APP_RD: state_r <= S_APP_WR;
        S_APP_WR: begin
          if (last_pos) begin
            if (removed_r) begin
              state_r <= S_SUB;
            end else begin
              c_r     <= '0;
              r_r     <= '0;
              base_r  <= '0;
              state_r <= S_B2;
            end
          end else begin
            c_r     <= c_nxt;
            r_r     <= r_nxt;
            base_r  <= base_nxt;
            state_r <= S_APP_RD;
          end
        end
        S_B2: begin
          if (last_pos) begin
            state_r <= S_RESP;
          end else begin
            c_r    <= c_nxt;
            r_r    <= r_nxt;
            base_r <= base_nxt;
          end
        end
        S_RESP: begin
          out_valid_r <= 1'b1;
          out_pix_r   <= (cmd_r == CMD_READ) && inside_r && px_rdata;
          out_cnt_r   <= cnt_r;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A new item is never taken while a result is still pending.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !out_valid_r)
    else $error("item accepted while a result is pending");

  // The response state always presents a result on the next cycle.
  a_resp_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) |=> out_valid)
    else $error("response state gave no result");

  // Removal never touches the border ring of the area in use.
  a_apply_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APP_WR && px_we) |-> (c_r != '0 && r_r != '0 && !on_border))
    else $error("removal write on the border");

  // A finished run has made at least one sub-pass.
  a_run_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_B2) |-> (cnt_r != '0))
    else $error("run finished without a sub-pass");

endmodule

### bench/binary_thinning_two_subpass_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the binary thinning block with its own image predictor.
module binary_thinning_two_subpass_tb;
  import bthin_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int STORE_W = 256;
  localparam int STORE_H = 256;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [7:0]  in_pixel_col;
  logic [7:0]  in_pixel_row;
  logic        in_pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_pixel_out;
  logic [15:0] out_subpass_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  binary_thinning_two_subpass dut (.*);

  // Expected result of one item.
  typedef struct {
    logic        pix;
    logic [15:0] passes;
  } answer_t;

  // One row of the directed stimulus; typed answers are used where known.
  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  col;
    logic [7:0]  row;
    logic        pix;
    bit          typed;
    logic        ans_pix;
    logic [15:0] ans_passes;
  } row_t;

  // Image predictor state.
  bit          img     [0:STORE_W*STORE_H-1];
  bit          written [0:STORE_W*STORE_H-1];
  bit          marks   [0:STORE_W*STORE_H-1];
  logic [15:0] pass_cnt;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  int          known_addrs[$];

  answer_t answers_q[$];
  bit      failed;
  int      cycles;
  int      random_items;

  // Clock and cycle limit.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int eff_size(logic [8:0] v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic bit pel(int c, int r);
    return img[r*STORE_W + c];
  endfunction

  function automatic void clear_edges(int w, int h);
    for (int i = 0; i < h; i++) begin
      img[i*STORE_W] = 0;
      img[i*STORE_W + w - 1] = 0;
      written[i*STORE_W] = 1;
      written[i*STORE_W + w - 1] = 1;
    end
    for (int i = 0; i < w; i++) begin
      img[i] = 0;
      img[(h-1)*STORE_W + i] = 0;
      written[i] = 1;
      written[(h-1)*STORE_W + i] = 1;
    end
  endfunction

  // Decide whether a set interior pixel is peeled in the given phase.
  function automatic bit peelable(int c, int r, bit ph);
    bit n[9];
    int cnt;
    int trans;
    n[0] = pel(c-1, r-1);
    n[1] = pel(c-1, r);
    n[2] = pel(c-1, r+1);
    n[3] = pel(c, r+1);
    n[4] = pel(c+1, r+1);
    n[5] = pel(c+1, r);
    n[6] = pel(c+1, r-1);
    n[7] = pel(c, r-1);
    n[8] = n[0];
    cnt = 0;
    trans = 0;
    for (int p = 0; p < 8; p++) begin
      cnt += int'(n[p]);
      if (!n[p] && n[p+1]) trans++;
    end
    if (cnt < 2 || cnt > 6 || trans != 1) return 0;
    if (ph) return !n[1] || !n[7] || (!n[3] && !n[5]);
    return !n[3] || !n[5] || (!n[1] && !n[7]);
  endfunction

  // Full thinning run on the predicted image.
  function automatic void thin_image();
    int w;
    int h;
    bit ph;
    bit removed;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    ph = 0;
    removed = 1;
    pass_cnt = 0;
    clear_edges(w, h);
    while (removed) begin
      ph = ~ph;
      if (pass_cnt != 16'hFFFF) pass_cnt++;
      removed = 0;
      for (int r = 1; r + 1 < h; r++)
        for (int c = 1; c + 1 < w; c++)
          if (pel(c, r) && peelable(c, r, ph)) begin
            marks[r*STORE_W + c] = 1;
            removed = 1;
          end
      for (int r = 1; r + 1 < h; r++)
        for (int c = 1; c + 1 < w; c++)
          if (marks[r*STORE_W + c]) begin
            marks[r*STORE_W + c] = 0;
            img[r*STORE_W + c] = 0;
          end
    end
    clear_edges(w, h);
  endfunction

  // Apply one accepted item to the predictor and return its result.
  function automatic answer_t apply_item(logic [1:0] cmd, logic [7:0] col, logic [7:0] row,
                                         logic pix);
    answer_t a;
    int addr;
    addr = int'(row)*STORE_W + int'(col);
    a.pix = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        img[addr] = pix;
        if (!written[addr]) known_addrs.push_back(addr);
        written[addr] = 1;
      end
      CMD_RUN: thin_image();
      CMD_READ: a.pix = img[addr];
      default: ;
    endcase
    a.passes = pass_cnt;
    return a;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item; the expectation is pushed at acceptance.
  task automatic send_item(logic [1:0] cmd, logic [7:0] col, logic [7:0] row, logic pix,
                           bit typed, answer_t typed_ans);
    int gap;
    answer_t a;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_pixel_col <= col;
    in_pixel_row <= row;
    in_pixel_in  <= pix;
    do @(posedge clk); while (in_stall);
    a = apply_item(cmd, col, row, pix);
    answers_q.push_back(typed ? typed_ans : a);
  endtask

  task automatic send_random(logic [1:0] cmd, logic [7:0] col, logic [7:0] row, logic pix);
    answer_t none;
    none = '{1'b0, 16'd0};
    send_item(cmd, col, row, pix, 0, none);
    random_items++;
  endtask

  // Wait for all results, then write one register.
  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic read_known();
    int addr;
    addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    send_random(CMD_READ, 8'(addr % STORE_W), 8'(addr / STORE_W), 1'($urandom_range(0, 1)));
  endtask

  // One phase: fill the interior of the area in use, mix in noise, run, read back.
  task automatic image_phase();
    int w;
    int h;
    int style;
    int c0;
    int c1;
    int r0;
    int r1;
    bit p;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    style = $urandom_range(0, 2);
    c0 = $urandom_range(1, w - 2);
    c1 = $urandom_range(c0, w - 2);
    r0 = $urandom_range(1, h - 2);
    r1 = $urandom_range(r0, h - 2);
    for (int r = 1; r + 1 < h; r++)
      for (int c = 1; c + 1 < w; c++) begin
        case (style)
          0: p = ($urandom_range(0, 9) < 7);
          1: p = (c >= c0 && c <= c1 && r >= r0 && r <= r1);
          default: p = 1'($urandom_range(0, 1));
        endcase
        send_random(CMD_LOAD, 8'(c), 8'(r), p);
        if ($urandom_range(0, 15) == 0) read_known();
        if ($urandom_range(0, 40) == 0)
          send_random(CMD_NONE, 8'($urandom), 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 20) == 0)
          send_random(CMD_LOAD, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    send_random(CMD_RUN, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(4, 12)) read_known();
    for (int i = 0; i < 4; i++)
      send_random(CMD_READ, 8'($urandom_range(0, w - 1)), 8'($urandom_range(0, h - 1)), 1'b0);
    if ($urandom_range(0, 3) == 0) send_random(CMD_RUN, 8'd0, 8'd0, 1'b0);
  endtask

  // Result checking.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d count=%0d", $time, out_pixel_out,
                 out_subpass_count);
        failed = 1'b1;
      end else begin
        if (out_pixel_out !== answers_q[0].pix) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, answers_q[0].pix,
                   out_pixel_out);
          failed = 1'b1;
        end
        if (out_subpass_count !== answers_q[0].passes) begin
          $display("%0t: subpass_count expected %0d actual %0d", $time,
                   answers_q[0].passes, out_subpass_count);
          failed = 1'b1;
        end
        void'(answers_q.pop_front());
      end
    end
  end

  // Receiver stall: calm stretches and busy stretches.
  always @(posedge clk) begin
    if ((cycles / 2000) % 3 == 0) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 9) < 8) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // Directed items at a 5x5 image.
  row_t script[$];

  initial begin
    answer_t ta;
    int w_pick;
    int h_pick;
    cycles = 0;
    failed = 0;
    random_items = 0;
    pass_cnt = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    for (int i = 0; i < STORE_W*STORE_H; i++) begin
      img[i] = 0;
      written[i] = 0;
      marks[i] = 0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_pixel_col = '0;
    in_pixel_row = '0;
    in_pixel_in = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_WIDTH, 9'd5);
    write_reg(CFG_HEIGHT, 9'd5);
    script.push_back('{CMD_LOAD, 8'd255, 8'd255, 1'b1, 1, 1'b0, 16'd0});
    script.push_back('{CMD_READ, 8'd255, 8'd255, 1'b0, 1, 1'b1, 16'd0});
    script.push_back('{CMD_LOAD, 8'd0, 8'd255, 1'b0, 1, 1'b0, 16'd0});
    script.push_back('{CMD_READ, 8'd0, 8'd255, 1'b1, 1, 1'b0, 16'd0});
    script.push_back('{CMD_NONE, 8'd255, 8'd255, 1'b1, 1, 1'b0, 16'd0});
    for (int r = 1; r <= 3; r++)
      for (int c = 1; c <= 3; c++)
        script.push_back('{CMD_LOAD, c[7:0], r[7:0], 1'b1, 0, 1'b0, 16'd0});
    script.push_back('{CMD_LOAD, 8'd0, 8'd0, 1'b1, 0, 1'b0, 16'd0});
    script.push_back('{CMD_RUN, 8'd0, 8'd0, 1'b0, 0, 1'b0, 16'd0});
    script.push_back('{CMD_READ, 8'd2, 8'd2, 1'b0, 0, 1'b0, 16'd0});
    script.push_back('{CMD_READ, 8'd0, 8'd0, 1'b0, 0, 1'b0, 16'd0});
    script.push_back('{CMD_READ, 8'd1, 8'd1, 1'b0, 0, 1'b0, 16'd0});
    script.push_back('{CMD_RUN, 8'd0, 8'd0, 1'b0, 0, 1'b0, 16'd0});
    foreach (script[i]) begin
      ta.pix = script[i].ans_pix;
      ta.passes = script[i].ans_passes;
      send_item(script[i].cmd, script[i].col, script[i].row, script[i].pix,
                script[i].typed, ta);
    end

    // Sizes at and beyond the extremes first, then small random ones.
    for (int ph = 0; random_items < RANDOM_ITEMS; ph++) begin
      case (ph)
        0: begin w_pick = 3; h_pick = 3; end
        1: begin w_pick = 256; h_pick = 3; end
        2: begin w_pick = 3; h_pick = 256; end
        3: begin w_pick = 511; h_pick = 4; end
        4: begin w_pick = 0; h_pick = 9; end
        5: begin w_pick = 10; h_pick = 1; end
        default: begin
          w_pick = $urandom_range(3, 14);
          h_pick = $urandom_range(3, 14);
        end
      endcase
      write_reg(CFG_WIDTH, w_pick[8:0]);
      write_reg(CFG_HEIGHT, h_pick[8:0]);
      image_phase();
    end

    in_valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
